// ===== design/pidaw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and saturating arithmetic helpers for the PID controller.
package pidaw_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int POLE_WIDTH    = 18;
    localparam int CFG_IDX_WIDTH = 3;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [POLE_WIDTH-1:0] pole_t;
    typedef logic signed [DATA_WIDTH+1:0] wide_t;

    localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INTEG_GAIN  = 3'd1,
        CFG_DERIV_GAIN  = 3'd2,
        CFG_FILTER_POLE = 3'd3,
        CFG_OUT_MIN     = 3'd4,
        CFG_OUT_MAX     = 3'd5,
        CFG_INTEG_MIN   = 3'd6,
        CFG_INTEG_MAX   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        data_t prop_gain;
        data_t integ_gain;
        data_t deriv_gain;
        pole_t filter_pole;
        data_t out_min;
        data_t out_max;
        data_t integ_min;
        data_t integ_max;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        prop_gain:   '0,
        integ_gain:  '0,
        deriv_gain:  '0,
        filter_pole: '0,
        out_min:     DATA_MIN,
        out_max:     DATA_MAX,
        integ_min:   DATA_MIN,
        integ_max:   DATA_MAX
    };

    typedef struct packed {
        data_t target;
        data_t sensed;
    } sample_t;

    typedef struct packed {
        data_t drive;
    } result_t;

    // Gain products that do not depend on the recurrent state.
    typedef struct packed {
        data_t p;
        data_t gi;
        data_t gd;
    } prod_t;

    // Terms that make up the controller output.
    typedef struct packed {
        data_t p;
        data_t integ;
        data_t deriv;
    } terms_t;

    // Saturate a value two bits wider than the data width.
    function automatic data_t sat_wide(input wide_t x);
        data_t r;
        if (x[DATA_WIDTH+1:DATA_WIDTH-1] == 3'b000 || x[DATA_WIDTH+1:DATA_WIDTH-1] == 3'b111)
        begin
            r = x[DATA_WIDTH-1:0];
        end
        else if (x[DATA_WIDTH+1])
        begin
            r = DATA_MIN;
        end
        else
        begin
            r = DATA_MAX;
        end
        return r;
    endfunction

    function automatic data_t add_sat(input data_t a, input data_t b);
        return sat_wide(wide_t'(a) + wide_t'(b));
    endfunction

    function automatic data_t sub_sat(input data_t a, input data_t b);
        return sat_wide(wide_t'(a) - wide_t'(b));
    endfunction

    function automatic data_t add3_sat(input data_t a, input data_t b, input data_t c);
        return sat_wide(wide_t'(a) + wide_t'(b) + wide_t'(c));
    endfunction

    // The upper limit is tested first, so a crossed pair of limits resolves
    // to the upper limit for values above it and the lower limit otherwise.
    function automatic data_t clamp(input data_t x, input data_t lo, input data_t hi);
        data_t r;
        if (x > hi)
        begin
            r = hi;
        end
        else if (x < lo)
        begin
            r = lo;
        end
        else
        begin
            r = x;
        end
        return r;
    endfunction

endpackage

// ===== design/pidaw_sample_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel that carries one setpoint and measurement pair per beat.
interface pidaw_sample_if
    import pidaw_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/pidaw_result_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel that carries one controller drive value per beat.
interface pidaw_result_if
    import pidaw_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/pidaw_mulq.sv =====
`timescale 1ns / 1ps
// Signed fixed-point multiplier with round-half-away-from-zero and saturation.
module pidaw_mulq
    import pidaw_pkg::*;
#(
    parameter int A_WIDTH   = 32,
    parameter int B_WIDTH   = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic signed [A_WIDTH-1:0] a,
    input  logic signed [B_WIDTH-1:0] b,
    output data_t                     y
);

    localparam int PW = A_WIDTH + B_WIDTH;
    localparam logic signed [PW-1:0] HALF   = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] LIM_HI = PW'(DATA_MAX);
    localparam logic signed [PW-1:0] LIM_LO = PW'(DATA_MIN);

    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] rounded;
    logic signed [PW-1:0] shifted;

    // For a negative product, adding half minus one before the arithmetic
    // shift rounds the magnitude up on a tie, matching sign-magnitude rounding.
    always_comb
    begin
        prod    = PW'(a) * PW'(b);
        rounded = prod + HALF - PW'(prod[PW-1]);
        shifted = rounded >>> FRAC_BITS;
        if (shifted > LIM_HI)
        begin
            y = DATA_MAX;
        end
        else if (shifted < LIM_LO)
        begin
            y = DATA_MIN;
        end
        else
        begin
            y = shifted[DATA_WIDTH-1:0];
        end
    end

endmodule

// ===== design/pidaw_front.sv =====
`timescale 1ns / 1ps
// Input register, error and measurement-change terms, and the three gain products.
module pidaw_front
    import pidaw_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    pidaw_sample_if.sink        sample,
    input  cfg_t                cfg,
    output logic                fwd_valid,
    input  logic                fwd_ready,
    output prod_t               fwd
);

    logic    s1_valid_reg;
    logic    s1_valid_next;
    sample_t s1_reg;
    logic    s2_valid_reg;
    logic    s2_valid_next;
    prod_t   prod_reg;
    prod_t   prod_next;
    data_t   last_error_reg;
    data_t   last_sensed_reg;

    logic    s2_load;
    data_t   err;
    data_t   err_sum;
    data_t   meas_delta;

    assign s2_load      = s1_valid_reg && (!s2_valid_reg || fwd_ready);
    assign sample.ready = !s1_valid_reg || s2_load;

    assign s1_valid_next = sample.ready ? sample.valid : s1_valid_reg;
    assign s2_valid_next = (!s2_valid_reg || fwd_ready) ? s1_valid_reg : s2_valid_reg;

    assign err        = sub_sat(s1_reg.target, s1_reg.sensed);
    assign err_sum    = add_sat(err, last_error_reg);
    assign meas_delta = sub_sat(s1_reg.sensed, last_sensed_reg);

    pidaw_mulq #(
        .A_WIDTH   (DATA_WIDTH),
        .B_WIDTH   (DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul_prop (
        .a (cfg.prop_gain),
        .b (err),
        .y (prod_next.p)
    );

    pidaw_mulq #(
        .A_WIDTH   (DATA_WIDTH),
        .B_WIDTH   (DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul_integ (
        .a (cfg.integ_gain),
        .b (err_sum),
        .y (prod_next.gi)
    );

    pidaw_mulq #(
        .A_WIDTH   (DATA_WIDTH),
        .B_WIDTH   (DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul_deriv (
        .a (cfg.deriv_gain),
        .b (meas_delta),
        .y (prod_next.gd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            last_error_reg  <= '0;
            last_sensed_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            if (s2_load)
            begin
                last_error_reg  <= err;
                last_sensed_reg <= s1_reg.sensed;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_reg <= sample.data;
        end
        if (s2_load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign fwd_valid = s2_valid_reg;
    assign fwd       = prod_reg;

endmodule

// ===== design/pidaw_core.sv =====
`timescale 1ns / 1ps
// Recurrent state: clamped trapezoidal integrator and filtered derivative.
module pidaw_core
    import pidaw_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   fwd_valid,
    output logic   fwd_ready,
    input  prod_t  fwd,
    output logic   acc_valid,
    input  logic   acc_ready,
    output terms_t acc
);

    logic  s3_valid_reg;
    logic  s3_valid_next;
    data_t p3_reg;
    data_t integ_acc_reg;
    data_t integ_next;
    data_t deriv_acc_reg;
    data_t deriv_next;
    data_t pole_prod;
    logic  load;

    assign fwd_ready     = !s3_valid_reg || acc_ready;
    assign load          = fwd_valid && fwd_ready;
    assign s3_valid_next = fwd_ready ? fwd_valid : s3_valid_reg;

    pidaw_mulq #(
        .A_WIDTH   (POLE_WIDTH),
        .B_WIDTH   (DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul_pole (
        .a (cfg.filter_pole),
        .b (deriv_acc_reg),
        .y (pole_prod)
    );

    assign integ_next = clamp(add_sat(integ_acc_reg, fwd.gi), cfg.integ_min, cfg.integ_max);
    assign deriv_next = sub_sat(pole_prod, fwd.gd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            integ_acc_reg <= '0;
            deriv_acc_reg <= '0;
        end
        else
        begin
            s3_valid_reg <= s3_valid_next;
            if (load)
            begin
                integ_acc_reg <= integ_next;
                deriv_acc_reg <= deriv_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            p3_reg <= fwd.p;
        end
    end

    assign acc_valid = s3_valid_reg;
    assign acc.p     = p3_reg;
    assign acc.integ = integ_acc_reg;
    assign acc.deriv = deriv_acc_reg;

`ifndef ASSERT_OFF
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> $stable(integ_acc_reg) && $stable(deriv_acc_reg))
        else $error("integrator or derivative state changed without a beat");

    a_integ_limit: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (integ_acc_reg <= $past(cfg.integ_max)) ||
                 (integ_acc_reg == $past(cfg.integ_min)))
        else $error("integrator left its anti-windup limits");
`endif

endmodule

// ===== design/pidaw_out.sv =====
`timescale 1ns / 1ps
// Output sum, output clamp and result register.
module pidaw_out
    import pidaw_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          acc_valid,
    output logic          acc_ready,
    input  terms_t        acc,
    pidaw_result_if.source result
);

    logic  out_valid_reg;
    logic  out_valid_next;
    data_t drive_reg;
    data_t drive_next;
    logic  load;

    assign acc_ready      = !out_valid_reg || result.ready;
    assign load           = acc_valid && acc_ready;
    assign out_valid_next = acc_ready ? acc_valid : out_valid_reg;

    assign drive_next = clamp(add3_sat(acc.p, acc.integ, acc.deriv), cfg.out_min, cfg.out_max);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg <= drive_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.data.drive = drive_reg;

`ifndef ASSERT_OFF
    a_drop_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(result.ready))
        else $error("result beat dropped before it was taken");

    a_drive_limit: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (drive_reg <= $past(cfg.out_max)) || (drive_reg == $past(cfg.out_min)))
        else $error("drive outside the output limits");
`endif

endmodule

// ===== design/pid_controller_antiwindup_top.sv =====
`timescale 1ns / 1ps
// Top level of the discrete PID controller with integrator anti-windup.

// Each sample beat carries a setpoint and a measurement in signed Q16.16 and
// produces exactly one drive beat: a proportional term on the error, a
// trapezoidal integrator clamped to integ_min..integ_max, a band-limited
// derivative on the measurement, and their saturated sum clamped to
// out_min..out_max. All sums saturate and every product rounds to nearest with
// ties away from zero. The block takes one sample every clock cycle while the
// result side does not stall; a taken sample moves through the sample, product,
// state and result registers. The cycle rate is set by the derivative filter
// recurrence, where the filter pole multiplies the previous derivative value
// and the new value is written back in the same cycle. The four pipeline
// registers each hold their beat on their own valid bit, so backpressure from
// the result side only stalls the stages that are full. The integrator,
// derivative, previous error and previous measurement all clear on reset.
// Registers are written through wr_en/wr_index/wr_data and should only be
// changed while no sample is in flight.
module pid_controller_antiwindup_top
    import pidaw_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    pidaw_sample_if.sink             sample,
    pidaw_result_if.source           result,
    input  logic                     wr_en,
    input  logic [CFG_IDX_WIDTH-1:0] wr_index,
    input  logic [DATA_WIDTH-1:0]    wr_data
);

    cfg_t   cfg_reg;
    cfg_t   cfg_next;

    logic   fwd_valid;
    logic   fwd_ready;
    prod_t  fwd;
    logic   acc_valid;
    logic   acc_ready;
    terms_t acc;

    // Register writes; the filter pole keeps only its own low bits.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                CFG_PROP_GAIN:   cfg_next.prop_gain   = wr_data;
                CFG_INTEG_GAIN:  cfg_next.integ_gain  = wr_data;
                CFG_DERIV_GAIN:  cfg_next.deriv_gain  = wr_data;
                CFG_FILTER_POLE: cfg_next.filter_pole = wr_data[POLE_WIDTH-1:0];
                CFG_OUT_MIN:     cfg_next.out_min     = wr_data;
                CFG_OUT_MAX:     cfg_next.out_max     = wr_data;
                CFG_INTEG_MIN:   cfg_next.integ_min   = wr_data;
                CFG_INTEG_MAX:   cfg_next.integ_max   = wr_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sample register, then the error terms and the three gain products.
    pidaw_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .cfg       (cfg_reg),
        .fwd_valid (fwd_valid),
        .fwd_ready (fwd_ready),
        .fwd       (fwd)
    );

    // Integrator and derivative filter state, updated once per beat.
    pidaw_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .fwd_valid (fwd_valid),
        .fwd_ready (fwd_ready),
        .fwd       (fwd),
        .acc_valid (acc_valid),
        .acc_ready (acc_ready),
        .acc       (acc)
    );

    // Final sum, output clamp and the result register.
    pidaw_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .acc_valid (acc_valid),
        .acc_ready (acc_ready),
        .acc       (acc),
        .result    (result)
    );

endmodule
